// ----- src/l2c_pkg.sv -----
// Package for the block-address to cylinder/head/sector converter: widths, types, divide step.
package l2c_pkg;

  localparam int ADDR_W    = 16;
  localparam int SPT_W     = 6;
  localparam int HEADS_W   = 8;
  localparam int CYL_W     = 16;
  localparam int CFG_W     = 8;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 32;

  // Quotient bits resolved per pipeline stage
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = ADDR_W / BITS_PER_STAGE;
  localparam int NUM_STAGES     = 2 * DIV_STAGES;

  localparam logic [SPT_W-1:0]   SPT_RESET   = SPT_W'(18);
  localparam logic [HEADS_W-1:0] HEADS_RESET = HEADS_W'(2);
  localparam logic [SPT_W-1:0]   SECTOR_BASE = SPT_W'(1);

  typedef enum logic [0:0] {
    REG_SECTORS_PER_TRACK = 1'b0,
    REG_HEAD_COUNT        = 1'b1
  } reg_index_t;

  // Partial quotient, running remainder and the sector found by the first divide
  typedef struct packed {
    logic [ADDR_W-1:0]  quo;
    logic [HEADS_W-1:0] rem;
    logic [SPT_W-1:0]   sector;
  } stage_t;

  // Restoring long division over BITS_PER_STAGE bits; divisor is never zero
  function automatic stage_t div_bits(stage_t s, logic [HEADS_W-1:0] divisor);
    logic [HEADS_W:0] trial;
    stage_t o;
    o = s;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      trial = {o.rem, o.quo[ADDR_W-1]};
      o.quo = {o.quo[ADDR_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        o.quo[0] = 1'b1;
      end
      o.rem = trial[HEADS_W-1:0];
    end
    return o;
  endfunction

endpackage

// ----- src/lba_to_chs_converter.sv -----
// Top level: pipelined block-address to cylinder/head/sector converter.
//
//  channel | direction | fields (low bit first)
//  s_axis  | in        | tdata: block_address[15:0]
//  m_axis  | out       | tdata: head_number[7:0], cylinder_number[15:0], sector_number[5:0], pad
//  cfg     | in        | 0 sectors_per_track, 1 head_count
//
// Two long divisions (by sectors per track, then by head count) run in registered stages,
// four quotient bits per stage. One item enters every cycle unless a full pipeline is stalled.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
// The last stage is the output register. Reset empties the pipeline and loads
// the registers with 18 sectors per track and 2 heads.
module lba_to_chs_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [l2c_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // block_address
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [l2c_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // head, cylinder, sector, zero pad
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_addr,
  input  logic [l2c_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int NS = l2c_pkg::NUM_STAGES;

  logic [l2c_pkg::SPT_W-1:0]   spt;
  logic [l2c_pkg::HEADS_W-1:0] heads;

  logic              valid [NS];
  l2c_pkg::stage_t   stage [NS];
  logic              rdy   [NS+1];
  l2c_pkg::stage_t   stage_in [NS];

  // Zero written to a register acts as one
  always_ff @(posedge clk) begin
    if (rst) begin
      spt   <= l2c_pkg::SPT_RESET;
      heads <= l2c_pkg::HEADS_RESET;
    end else if (cfg_we) begin
      unique case (l2c_pkg::reg_index_t'(cfg_addr))
        l2c_pkg::REG_SECTORS_PER_TRACK: begin
          spt <= (cfg_wdata[l2c_pkg::SPT_W-1:0] == '0) ? l2c_pkg::SPT_W'(1)
                                                        : cfg_wdata[l2c_pkg::SPT_W-1:0];
        end
        l2c_pkg::REG_HEAD_COUNT: begin
          heads <= (cfg_wdata == '0) ? l2c_pkg::HEADS_W'(1) : cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_comb begin
    stage_in[0] = l2c_pkg::div_bits(
      '{quo: s_axis_tdata[l2c_pkg::ADDR_W-1:0], rem: '0, sector: '0},
      {2'b00, spt});
    for (int k = 1; k < NS; k++) begin
      if (k < l2c_pkg::DIV_STAGES) begin
        stage_in[k] = l2c_pkg::div_bits(stage[k-1], {2'b00, spt});
      end else if (k == l2c_pkg::DIV_STAGES) begin
        // Track index becomes the next dividend; keep the sector
        stage_in[k] = l2c_pkg::div_bits(
          '{quo: stage[k-1].quo, rem: '0,
            sector: stage[k-1].rem[l2c_pkg::SPT_W-1:0] + l2c_pkg::SECTOR_BASE},
          heads);
      end else begin
        stage_in[k] = l2c_pkg::div_bits(stage[k-1], heads);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        valid[k] <= 1'b0;
      end
    end else begin
      if (rdy[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        stage[k] <= stage_in[k];
      end
    end
  end

  assign m_axis_tvalid = valid[NS-1];
  assign m_axis_tdata  = {2'b00, stage[NS-1].sector,
                          stage[NS-1].quo[l2c_pkg::CYL_W-1:0], stage[NS-1].rem};

endmodule

// ----- src/l2c_checker.sv -----
// Port-level checker for the converter, bound to the top level.
module l2c_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [l2c_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // Empty pipeline after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // With the output stage empty, no stage can block input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // Sectors count from one
  a_sector_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[29:24] != 6'd0))
    else $error("sector number zero");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind lba_to_chs_converter l2c_checker u_l2c_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_lba_to_chs_converter.sv -----
// Self-checking testbench for lba_to_chs_converter: geometry writes, random addresses, stalls.
module tb_lba_to_chs_converter;

  localparam int LATENCY     = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int BATCHES     = 8;
  localparam int BATCH_ITEMS = 60;

  typedef struct packed {
    logic [7:0]  head;
    logic [15:0] cylinder;
    logic [5:0]  sector;
  } chs_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [l2c_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;   // block_address
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [l2c_pkg::OUT_DATA_W-1:0]  m_axis_tdata;  // head_number, cylinder_number, sector_number, pad
  logic                            cfg_we = 1'b0;
  logic [0:0]                      cfg_addr = '0;
  logic [l2c_pkg::CFG_W-1:0]       cfg_wdata = '0;

  // Geometry as the block should currently hold it
  logic [5:0] spt_cfg   = 6'd18;
  logic [7:0] heads_cfg = 8'd2;

  logic [15:0] pending_lba[$];
  chs_t        expected_chs[$];

  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 81;
  int          error_count   = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          hold_left     = 0;

  lba_to_chs_converter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A zero geometry register behaves as one
  function automatic chs_t locate_block(input logic [15:0] lba, input logic [5:0] spt,
                                        input logic [7:0] heads);
    int unsigned s, h, a;
    chs_t r;
    s = (spt == '0) ? 1 : 32'(spt);
    h = (heads == '0) ? 1 : 32'(heads);
    a = 32'(lba);
    r.head     = 8'((a / s) % h);
    r.cylinder = 16'(a / (s * h));
    r.sector   = 6'((a % s) + 1);
    return r;
  endfunction

  // Mix of full-range, small, top-of-range and track/cylinder boundary addresses
  function automatic logic [15:0] pick_lba();
    int unsigned s, h, span, k;
    logic [15:0] lba;
    s    = (spt_cfg == '0) ? 1 : 32'(spt_cfg);
    h    = (heads_cfg == '0) ? 1 : 32'(heads_cfg);
    span = s * h;
    case ($urandom_range(5))
      0, 1: lba = 16'($urandom);
      2: lba = 16'($urandom_range(255));
      3: lba = 16'(65535 - $urandom_range(63));
      4: begin
        k   = $urandom_range(65535 / span);
        lba = 16'(k * span + $urandom_range(2) - 1);
      end
      default: begin
        k   = $urandom_range(65535 / s);
        lba = 16'(k * s + (($urandom_range(1) == 0) ? 0 : s - 1));
      end
    endcase
    return lba;
  endfunction

  // Low bound, high bound, a raw byte (zero and wide values included), or in range
  function automatic logic [7:0] pick_geometry(input int unsigned hi);
    logic [7:0] v;
    case ($urandom_range(3))
      0: v = 8'd1;
      1: v = 8'(hi);
      2: v = 8'($urandom_range(255));
      default: v = 8'($urandom_range(hi, 1));
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input logic [l2c_pkg::OUT_DATA_W-1:0] data);
    chs_t want;
    if (expected_chs.size() == 0) begin
      report_mismatch("result with nothing outstanding, tdata", 32'(data), 0);
    end else begin
      want = expected_chs.pop_front();
      if (data[7:0] != want.head)
        report_mismatch("head_number", 32'(data[7:0]), 32'(want.head));
      if (data[23:8] != want.cylinder)
        report_mismatch("cylinder_number", 32'(data[23:8]), 32'(want.cylinder));
      if (data[29:24] != want.sector)
        report_mismatch("sector_number", 32'(data[29:24]), 32'(want.sector));
    end
  endtask

  task automatic write_reg(input l2c_pkg::reg_index_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      l2c_pkg::REG_SECTORS_PER_TRACK: spt_cfg = value[5:0];
      l2c_pkg::REG_HEAD_COUNT:        heads_cfg = value;
      default: ;
    endcase
  endtask

  // Hold off until every item has come back out, then let the pipeline settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_lba.size() != 0 || s_axis_tvalid || expected_chs.size() != 0);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Driver: offer the next address, record the expectation on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_chs.push_back(locate_block(s_axis_tdata, spt_cfg, heads_cfg));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_lba.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_lba.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then pick tready for the next edge
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_result(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_lba_to_chs_converter: done, errors");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: track and cylinder edges, address extremes, alternating bits
    pending_lba = '{16'd0, 16'd1, 16'd17, 16'd18, 16'd35, 16'd36, 16'hFFFF, 16'h8000,
                    16'h5555, 16'hAAAA};
    wait_drained();

    // Largest geometry
    write_reg(l2c_pkg::REG_SECTORS_PER_TRACK, 8'd63);
    write_reg(l2c_pkg::REG_HEAD_COUNT, 8'd255);
    @(negedge clk);
    pending_lba = '{16'hFFFF, 16'd62, 16'd63, 16'd16064, 16'd16065};
    wait_drained();

    // Smallest geometry: cylinder equals the address
    write_reg(l2c_pkg::REG_SECTORS_PER_TRACK, 8'd1);
    write_reg(l2c_pkg::REG_HEAD_COUNT, 8'd1);
    @(negedge clk);
    pending_lba = '{16'hFFFF, 16'd0};
    wait_drained();

    // Zero in both registers acts as one
    write_reg(l2c_pkg::REG_SECTORS_PER_TRACK, 8'd0);
    write_reg(l2c_pkg::REG_HEAD_COUNT, 8'd0);
    @(negedge clk);
    pending_lba = '{16'hFFFF, 16'd12345};
    wait_drained();

    // Upper write bits beyond the sectors-per-track width are dropped
    write_reg(l2c_pkg::REG_SECTORS_PER_TRACK, 8'hC5);
    write_reg(l2c_pkg::REG_HEAD_COUNT, 8'h80);
    @(negedge clk);
    pending_lba = '{16'hFFFF, 16'd7};
    wait_drained();

    for (int b = 0; b < BATCHES; b++) begin
      if (b == 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 30;
      end else if (b == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(l2c_pkg::REG_SECTORS_PER_TRACK, pick_geometry(63));
      write_reg(l2c_pkg::REG_HEAD_COUNT, pick_geometry(255));
      @(negedge clk);
      // Stall the output long enough for the pipeline to fill and push back
      if (b == 6)
        hold_requests++;
      repeat (BATCH_ITEMS) pending_lba.push_back(pick_lba());
      wait_drained();
    end

    if (error_count == 0 && expected_chs.size() == 0)
      $display("tb_lba_to_chs_converter: done, clean");
    else
      $display("tb_lba_to_chs_converter: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/l2c_pkg.sv
src/lba_to_chs_converter.sv
src/l2c_checker.sv
tb/sv/tb_lba_to_chs_converter.sv
